[rtl/core/sgbd_pkg.sv]
// Package for the scaled gray Bayer dither block: sizes, register indexes,
// shared structs and the 8x8 threshold table.
// Depends on nothing; every other file in rtl/core imports it.
package sgbd_pkg;

    localparam int MAX_IMAGE_SIDE  = 4096;
    localparam int MAX_SCREEN_SIDE = 2048;

    localparam int IMG_W   = $clog2(MAX_IMAGE_SIDE);
    localparam int SCR_W   = $clog2(MAX_SCREEN_SIDE);
    localparam int SCALE_W = 27;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = IMG_W + SCALE_W;
    localparam int POS_W   = PROD_W - FRAC_W;
    localparam int PIX_W   = 16;
    localparam int IDX_W   = 3;

    localparam int IN_W    = 2 * IMG_W + PIX_W;
    localparam int IN_BW   = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W   = 2 * SCR_W + 1;
    localparam int OUT_BW  = ((OUT_W + 7) / 8) * 8;

    localparam logic [IDX_W-1:0] REG_IMG_WIDTH     = 3'd0;
    localparam logic [IDX_W-1:0] REG_IMG_HEIGHT    = 3'd1;
    localparam logic [IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd2;
    localparam logic [IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd3;
    localparam logic [IDX_W-1:0] REG_LANDSCAPE     = 3'd4;
    localparam logic [IDX_W-1:0] REG_RIGHT_HALF    = 3'd5;
    localparam logic [IDX_W-1:0] REG_SCALE_X       = 3'd6;
    localparam logic [IDX_W-1:0] REG_SCALE_Y       = 3'd7;

    typedef struct packed {
        logic [IMG_W-1:0]   img_width;
        logic [IMG_W-1:0]   img_height;
        logic [SCR_W-1:0]   screen_width;
        logic [SCR_W-1:0]   screen_height;
        logic               landscape;
        logic               right_half;
        logic [SCALE_W-1:0] scale_x;
        logic [SCALE_W-1:0] scale_y;
    } sgbd_cfg_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } sgbd_load_t;

    localparam logic [7:0] BAYER_THR [0:63] = '{
        8'd0,   8'd191, 8'd47,  8'd239, 8'd11,  8'd203, 8'd59,  8'd251,
        8'd127, 8'd63,  8'd175, 8'd111, 8'd139, 8'd75,  8'd187, 8'd123,
        8'd31,  8'd223, 8'd15,  8'd207, 8'd43,  8'd235, 8'd27,  8'd219,
        8'd159, 8'd95,  8'd143, 8'd79,  8'd171, 8'd107, 8'd155, 8'd91,
        8'd7,   8'd199, 8'd55,  8'd247, 8'd3,   8'd195, 8'd51,  8'd243,
        8'd135, 8'd71,  8'd183, 8'd119, 8'd131, 8'd67,  8'd179, 8'd115,
        8'd39,  8'd231, 8'd23,  8'd215, 8'd35,  8'd227, 8'd19,  8'd211,
        8'd167, 8'd103, 8'd151, 8'd87,  8'd163, 8'd99,  8'd147, 8'd83
    };

endpackage

[rtl/core/sgbd_cfg_regs.sv]
// Configuration register file of the dither block, written by index.
// Depends on sgbd_pkg.
module sgbd_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [sgbd_pkg::IDX_W-1:0]  wr_index,
    input  logic [sgbd_pkg::SCALE_W-1:0] wr_data,
    output sgbd_pkg::sgbd_cfg_t         cfg
);
    import sgbd_pkg::*;

    sgbd_cfg_t cfg_reg;
    sgbd_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_IMG_WIDTH:     cfg_next.img_width     = wr_data[IMG_W-1:0];
                REG_IMG_HEIGHT:    cfg_next.img_height    = wr_data[IMG_W-1:0];
                REG_SCREEN_WIDTH:  cfg_next.screen_width  = wr_data[SCR_W-1:0];
                REG_SCREEN_HEIGHT: cfg_next.screen_height = wr_data[SCR_W-1:0];
                REG_LANDSCAPE:     cfg_next.landscape     = wr_data[0];
                REG_RIGHT_HALF:    cfg_next.right_half    = wr_data[0];
                REG_SCALE_X:       cfg_next.scale_x       = wr_data;
                REG_SCALE_Y:       cfg_next.scale_y       = wr_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/sgbd_coord.sv]
// Coordinate path: window check, half offset, 11.16 scaling and screen bound
// check over three register stages. Depends on sgbd_pkg.
module sgbd_coord (
    input  logic                       clk,
    input  sgbd_pkg::sgbd_load_t       load,
    input  sgbd_pkg::sgbd_cfg_t        cfg,
    input  logic [sgbd_pkg::IMG_W-1:0] src_x,
    input  logic [sgbd_pkg::IMG_W-1:0] src_y,
    output logic                       keep1,
    output logic                       keep3,
    output logic [sgbd_pkg::SCR_W-1:0] dest_x,
    output logic [sgbd_pkg::SCR_W-1:0] dest_y
);
    import sgbd_pkg::*;

    logic [IMG_W-1:0]  half;
    logic [IMG_W-1:0]  ex_next;
    logic [IMG_W-1:0]  ex_reg;
    logic [IMG_W-1:0]  ey_reg;
    logic [PROD_W-1:0] prod_x;
    logic [PROD_W-1:0] prod_y;
    logic [POS_W-1:0]  px_reg;
    logic [POS_W-1:0]  py_reg;
    logic [SCR_W-1:0]  dx_reg;
    logic [SCR_W-1:0]  dy_reg;

    always_comb
    begin
        half    = cfg.img_width >> 1;
        keep1   = (src_x < cfg.img_width) && (src_y < cfg.img_height);
        ex_next = src_x;
        if (cfg.landscape)
        begin
            if (cfg.right_half)
            begin
                keep1   = keep1 && (src_x >= half);
                ex_next = src_x - half;
            end
            else
            begin
                keep1 = keep1 && (src_x < half);
            end
        end
    end

    assign prod_x = PROD_W'(ex_reg) * PROD_W'(cfg.scale_x);
    assign prod_y = PROD_W'(ey_reg) * PROD_W'(cfg.scale_y);

    assign keep3 = (px_reg < POS_W'(cfg.screen_width))
                && (py_reg < POS_W'(cfg.screen_height));

    always_ff @(posedge clk)
    begin
        if (load.s1)
        begin
            ex_reg <= ex_next;
            ey_reg <= src_y;
        end
        if (load.s2)
        begin
            px_reg <= prod_x[PROD_W-1:FRAC_W];
            py_reg <= prod_y[PROD_W-1:FRAC_W];
        end
        if (load.s3)
        begin
            dx_reg <= px_reg[SCR_W-1:0];
            dy_reg <= py_reg[SCR_W-1:0];
        end
    end

    assign dest_x = dx_reg;
    assign dest_y = dy_reg;

endmodule

[rtl/core/sgbd_gray.sv]
// Color path: RGB565 expansion, luma, squaring and darkening over three
// register stages. Depends on sgbd_pkg.
module sgbd_gray (
    input  logic                       clk,
    input  sgbd_pkg::sgbd_load_t       load,
    input  logic [sgbd_pkg::PIX_W-1:0] pixel,
    output logic [7:0]                 gray
);
    import sgbd_pkg::*;

    logic [4:0]  r5;
    logic [5:0]  g6;
    logic [4:0]  b5;
    logic [7:0]  r8;
    logic [7:0]  g8;
    logic [7:0]  b8;
    logic [15:0] luma_sum;
    logic [7:0]  y1_reg;
    logic [7:0]  y2_reg;
    logic [15:0] sq_reg;
    logic [8:0]  dark_sum;
    logic [7:0]  gray_reg;

    always_comb
    begin
        r5       = pixel[15:11];
        g6       = pixel[10:5];
        b5       = pixel[4:0];
        r8       = {r5, r5[4:2]};
        g8       = {g6, g6[5:4]};
        b8       = {b5, b5[4:2]};
        luma_sum = (16'(r8) * 16'd77) + (16'(g8) * 16'd150) + (16'(b8) * 16'd29);
        dark_sum = 9'(y2_reg) + 9'(sq_reg[15:8]);
    end

    always_ff @(posedge clk)
    begin
        if (load.s1)
        begin
            y1_reg <= luma_sum[15:8];
        end
        if (load.s2)
        begin
            y2_reg <= y1_reg;
            sq_reg <= 16'(y1_reg) * 16'(y1_reg);
        end
        if (load.s3)
        begin
            gray_reg <= dark_sum[8:1];
        end
    end

    assign gray = gray_reg;

endmodule

[rtl/core/scaled_gray_bayer_dither.sv]
// Top level of the scaled gray Bayer dither block: stream handshake, valid
// pipeline, Bayer compare and output register. Depends on sgbd_pkg and on
// sgbd_cfg_regs, sgbd_coord and sgbd_gray.
//
//   channel   direction  handshake             payload
//   s_axis    in         s_tvalid / s_tready   s_tdata: src_x, src_y, pixel
//   m_axis    out        m_tvalid / m_tready   m_tdata: dest_x, dest_y, ink
//   cfg       in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item per cycle while m_tready holds high, through four register stages; a kept
// item passes v1_reg, v2_reg, v3_reg and v4_reg in order before it shows on m_tvalid.
// The two 12x27 scale multipliers and the luma square set the stage depth.
// Reset clears the valid bits and the configuration registers; cfg_ready is always high.
// Each stage moves whenever the one after it is empty or moving, so bubbles
// fill under an output stall and nothing is lost or repeated.
module scaled_gray_bayer_dither (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [sgbd_pkg::IN_BW-1:0]   s_tdata,   // src_x, src_y, pixel
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [sgbd_pkg::OUT_BW-1:0]  m_tdata,   // dest_x, dest_y, ink, zero
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [sgbd_pkg::IDX_W-1:0]   cfg_index,
    input  logic [sgbd_pkg::SCALE_W-1:0] cfg_data
);
    import sgbd_pkg::*;

    sgbd_cfg_t        cfg;
    sgbd_load_t       load;
    logic             keep1;
    logic             keep3;
    logic [SCR_W-1:0] dx3;
    logic [SCR_W-1:0] dy3;
    logic [7:0]       gray3;
    logic             v1_reg;
    logic             v2_reg;
    logic             v3_reg;
    logic             v4_reg;
    logic             rdy4;
    logic             ink_next;
    logic [SCR_W-1:0] dx4_reg;
    logic [SCR_W-1:0] dy4_reg;
    logic             ink4_reg;

    assign cfg_ready = 1'b1;

    sgbd_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign rdy4    = !v4_reg || m_tready;
    assign load.s3 = !v3_reg || rdy4;
    assign load.s2 = !v2_reg || load.s3;
    assign load.s1 = !v1_reg || load.s2;
    assign s_tready = load.s1;

    sgbd_coord u_coord (
        .clk    (clk),
        .load   (load),
        .cfg    (cfg),
        .src_x  (s_tdata[IMG_W-1:0]),
        .src_y  (s_tdata[2*IMG_W-1:IMG_W]),
        .keep1  (keep1),
        .keep3  (keep3),
        .dest_x (dx3),
        .dest_y (dy3)
    );

    sgbd_gray u_gray (
        .clk   (clk),
        .load  (load),
        .pixel (s_tdata[2*IMG_W+PIX_W-1:2*IMG_W]),
        .gray  (gray3)
    );

    assign ink_next = gray3 < BAYER_THR[{dy3[2:0], dx3[2:0]}];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (load.s1)
            begin
                v1_reg <= s_tvalid && keep1;
            end
            if (load.s2)
            begin
                v2_reg <= v1_reg;
            end
            if (load.s3)
            begin
                v3_reg <= v2_reg && keep3;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            dx4_reg  <= dx3;
            dy4_reg  <= dy3;
            ink4_reg <= ink_next;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = OUT_BW'({ink4_reg, dy4_reg, dx4_reg});

`ifndef SYNTHESIS
    a_dest_x_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (dx4_reg < cfg.screen_width))
        else $error("dest_x beyond screen width");

    a_dest_y_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (dy4_reg < cfg.screen_height))
        else $error("dest_y beyond screen height");

    a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without an output stall");

    a_held_output: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled output item changed");
`endif

endmodule

[tb/sv/tb_scaled_gray_bayer_dither.sv]
// Self-checking testbench for scaled_gray_bayer_dither: directed and random pixels
// under random stalls, each dot checked against an in-bench model of the mapping.
// Depends on sgbd_pkg and the scaled_gray_bayer_dither RTL.
`timescale 1ns / 1ps

module tb_scaled_gray_bayer_dither;

    import sgbd_pkg::*;

    localparam int          SETTLE_CYCLES = 10;
    localparam int          STALL_CYCLES  = 250;
    localparam int unsigned SCALE_TOP     = 134152192;
    localparam int unsigned UNITY         = 65536;

    localparam logic [7:0] ORDER_THRESHOLD [0:63] = '{
        8'd0,   8'd191, 8'd47,  8'd239, 8'd11,  8'd203, 8'd59,  8'd251,
        8'd127, 8'd63,  8'd175, 8'd111, 8'd139, 8'd75,  8'd187, 8'd123,
        8'd31,  8'd223, 8'd15,  8'd207, 8'd43,  8'd235, 8'd27,  8'd219,
        8'd159, 8'd95,  8'd143, 8'd79,  8'd171, 8'd107, 8'd155, 8'd91,
        8'd7,   8'd199, 8'd55,  8'd247, 8'd3,   8'd195, 8'd51,  8'd243,
        8'd135, 8'd71,  8'd183, 8'd119, 8'd131, 8'd67,  8'd179, 8'd115,
        8'd39,  8'd231, 8'd23,  8'd215, 8'd35,  8'd227, 8'd19,  8'd211,
        8'd167, 8'd103, 8'd151, 8'd87,  8'd163, 8'd99,  8'd147, 8'd83
    };

    typedef struct packed {
        logic [SCR_W-1:0] dest_x;
        logic [SCR_W-1:0] dest_y;
        logic             ink;
    } dot_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_BW-1:0]    s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_BW-1:0]   m_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [SCALE_W-1:0]  cfg_data = '0;

    sgbd_cfg_t shadow_cfg = '0;
    dot_t      expected_dots [$];
    int        error_count = 0;
    int        pixels_sent = 0;
    int        dots_checked = 0;
    int        configs_applied = 0;
    int        hold_request = 0;
    bit        tx_steady = 1'b0;
    bit        rx_steady = 1'b0;

    scaled_gray_bayer_dither i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("scaled_gray_bayer_dither: mismatch");
        $finish;
    end

    function automatic int pick_gap(input bit steady);
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Drop rules, half offset, 11.16 scaling, luma darkening and the Bayer compare.
    function automatic bit predict_dot(input logic [IMG_W-1:0] sx, input logic [IMG_W-1:0] sy,
                                       input logic [PIX_W-1:0] px, output dot_t dot);
        logic [IMG_W-1:0]  half;
        logic [IMG_W-1:0]  ex;
        logic [PROD_W-1:0] pos_x;
        logic [PROD_W-1:0] pos_y;
        logic [7:0]        r;
        logic [7:0]        g;
        logic [7:0]        b;
        int unsigned       luma;
        int unsigned       dark;
        dot = '0;
        half = shadow_cfg.img_width >> 1;
        ex = sx;
        if (sx >= shadow_cfg.img_width || sy >= shadow_cfg.img_height)
            return 1'b0;
        if (shadow_cfg.landscape)
        begin
            if (shadow_cfg.right_half != (sx >= half))
                return 1'b0;
            if (shadow_cfg.right_half)
                ex = sx - half;
        end
        pos_y = ({{SCALE_W{1'b0}}, sy} * {{IMG_W{1'b0}}, shadow_cfg.scale_y}) >> FRAC_W;
        if (pos_y >= shadow_cfg.screen_height)
            return 1'b0;
        pos_x = ({{SCALE_W{1'b0}}, ex} * {{IMG_W{1'b0}}, shadow_cfg.scale_x}) >> FRAC_W;
        if (pos_x >= shadow_cfg.screen_width)
            return 1'b0;
        r = {px[15:11], px[15:13]};
        g = {px[10:5], px[10:9]};
        b = {px[4:0], px[4:2]};
        luma = (r * 77 + g * 150 + b * 29) >> 8;
        dark = (luma + ((luma * luma) >> 8)) >> 1;
        dot.dest_x = pos_x[SCR_W-1:0];
        dot.dest_y = pos_y[SCR_W-1:0];
        dot.ink = dark < ORDER_THRESHOLD[{pos_y[2:0], pos_x[2:0]}];
        return 1'b1;
    endfunction

    function automatic sgbd_cfg_t make_cfg(input int unsigned w, input int unsigned h,
                                           input int unsigned sw, input int unsigned sh,
                                           input bit land, input bit right,
                                           input int unsigned scx, input int unsigned scy);
        sgbd_cfg_t c;
        c.img_width     = IMG_W'(w);
        c.img_height    = IMG_W'(h);
        c.screen_width  = SCR_W'(sw);
        c.screen_height = SCR_W'(sh);
        c.landscape     = land;
        c.right_half    = right;
        c.scale_x       = SCALE_W'(scx);
        c.scale_y       = SCALE_W'(scy);
        return c;
    endfunction

    task automatic drain_results(input int settle);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_dots.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [SCALE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_IMG_WIDTH:     shadow_cfg.img_width     = value[IMG_W-1:0];
            REG_IMG_HEIGHT:    shadow_cfg.img_height    = value[IMG_W-1:0];
            REG_SCREEN_WIDTH:  shadow_cfg.screen_width  = value[SCR_W-1:0];
            REG_SCREEN_HEIGHT: shadow_cfg.screen_height = value[SCR_W-1:0];
            REG_LANDSCAPE:     shadow_cfg.landscape     = value[0];
            REG_RIGHT_HALF:    shadow_cfg.right_half    = value[0];
            REG_SCALE_X:       shadow_cfg.scale_x       = value;
            REG_SCALE_Y:       shadow_cfg.scale_y       = value;
            default:           ;
        endcase
    endtask

    task automatic apply_config(input sgbd_cfg_t c);
        drain_results(SETTLE_CYCLES);
        write_reg(REG_IMG_WIDTH, SCALE_W'(c.img_width));
        write_reg(REG_IMG_HEIGHT, SCALE_W'(c.img_height));
        write_reg(REG_SCREEN_WIDTH, SCALE_W'(c.screen_width));
        write_reg(REG_SCREEN_HEIGHT, SCALE_W'(c.screen_height));
        write_reg(REG_LANDSCAPE, SCALE_W'(c.landscape));
        write_reg(REG_RIGHT_HALF, SCALE_W'(c.right_half));
        write_reg(REG_SCALE_X, c.scale_x);
        write_reg(REG_SCALE_Y, c.scale_y);
        cfg_valid <= 1'b0;
        configs_applied++;
    endtask

    task automatic send_pixel(input logic [IMG_W-1:0] sx, input logic [IMG_W-1:0] sy,
                              input logic [PIX_W-1:0] px);
        int   gap;
        dot_t dot;
        gap = pick_gap(tx_steady);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_BW'({px, sy, sx});
        do @(posedge clk); while (!s_tready);
        pixels_sent++;
        if (predict_dot(sx, sy, px, dot))
            expected_dots.push_back(dot);
    endtask

    // Mostly pixels inside the shown part of the image, some anywhere in the field range.
    task automatic send_random_pixels(input int count);
        logic [IMG_W-1:0] sx;
        logic [IMG_W-1:0] sy;
        int unsigned      w;
        int unsigned      h;
        int unsigned      half;
        w = 32'(shadow_cfg.img_width);
        h = 32'(shadow_cfg.img_height);
        half = w >> 1;
        for (int n = 0; n < count; n++)
        begin
            if (w == 0 || h == 0 || $urandom_range(0, 99) < 15)
            begin
                sx = IMG_W'($urandom_range(0, 4095));
                sy = IMG_W'($urandom_range(0, 4095));
            end
            else
            begin
                sy = IMG_W'($urandom_range(0, h - 1));
                if (shadow_cfg.landscape && $urandom_range(0, 9) != 0)
                begin
                    if (shadow_cfg.right_half)
                        sx = IMG_W'($urandom_range(half, w - 1));
                    else
                        sx = (half == 0) ? '0 : IMG_W'($urandom_range(0, half - 1));
                end
                else
                    sx = IMG_W'($urandom_range(0, w - 1));
            end
            send_pixel(sx, sy, PIX_W'($urandom_range(0, 65535)));
        end
    endtask

    task automatic test_reset_state();
        send_pixel(12'd0, 12'd0, 16'h0000);
        send_pixel(12'd4095, 12'd4095, 16'hFFFF);
    endtask

    task automatic test_empty_image();
        apply_config(make_cfg(4095, 0, 2047, 2047, 0, 0, UNITY, UNITY));
        send_pixel(12'd0, 12'd0, 16'hFFFF);
        send_pixel(12'd100, 12'd0, 16'h1234);
        apply_config(make_cfg(0, 4095, 2047, 2047, 1, 1, UNITY, UNITY));
        send_pixel(12'd0, 12'd0, 16'h0000);
    endtask

    task automatic test_portrait_bounds();
        apply_config(make_cfg(64, 48, 128, 96, 0, 0, 2 * UNITY, 2 * UNITY));
        send_pixel(12'd0, 12'd0, 16'h0000);
        send_pixel(12'd63, 12'd47, 16'hFFFF);
        send_pixel(12'd64, 12'd0, 16'hF800);
        send_pixel(12'd0, 12'd48, 16'h07E0);
        send_pixel(12'd4095, 12'd4095, 16'h001F);
        send_pixel(12'd7, 12'd5, 16'h8410);
        send_pixel(12'd63, 12'd0, 16'hFFFF);
        send_pixel(12'd0, 12'd47, 16'h0000);
    endtask

    // Odd width: the right half is one column wider and its last column lands off screen.
    task automatic test_landscape_halves();
        apply_config(make_cfg(65, 16, 100, 50, 1, 0, (100 * UNITY) / 32, (50 * UNITY) / 16));
        send_pixel(12'd31, 12'd0, 16'hAAAA);
        send_pixel(12'd32, 12'd0, 16'h5555);
        send_pixel(12'd0, 12'd15, 16'hFFFF);
        apply_config(make_cfg(65, 16, 100, 50, 1, 1, (100 * UNITY) / 32, (50 * UNITY) / 16));
        send_pixel(12'd31, 12'd0, 16'hAAAA);
        send_pixel(12'd32, 12'd0, 16'h5555);
        send_pixel(12'd64, 12'd15, 16'h0000);
    endtask

    task automatic test_scale_extremes();
        apply_config(make_cfg(4095, 4095, 2047, 2047, 0, 0, SCALE_TOP, SCALE_TOP));
        send_pixel(12'd0, 12'd0, 16'h7BEF);
        send_pixel(12'd1, 12'd1, 16'hFFFF);
        send_pixel(12'd4095, 12'd4095, 16'h0000);
        apply_config(make_cfg(4095, 4095, 2047, 2047, 0, 0, 0, 0));
        send_pixel(12'd4094, 12'd4094, 16'hFFFF);
        apply_config(make_cfg(4095, 4095, 0, 0, 0, 0, UNITY, UNITY));
        send_pixel(12'd0, 12'd0, 16'h0000);
    endtask

    task automatic test_backpressure();
        apply_config(make_cfg(64, 64, 64, 64, 0, 0, UNITY, UNITY));
        tx_steady = 1'b1;
        hold_request = STALL_CYCLES;
        send_random_pixels(60);
        tx_steady = 1'b0;
        drain_results(0);
        send_random_pixels(10);
        drain_results(0);
        send_random_pixels(10);
    endtask

    task automatic test_random_frames(input int frames, input int per_frame);
        sgbd_cfg_t   c;
        int unsigned span;
        for (int f = 0; f < frames; f++)
        begin
            c.img_width     = ($urandom_range(0, 3) == 0) ? IMG_W'($urandom_range(1, 4095))
                                                          : IMG_W'($urandom_range(1, 160));
            c.img_height    = ($urandom_range(0, 3) == 0) ? IMG_W'($urandom_range(1, 4095))
                                                          : IMG_W'($urandom_range(1, 160));
            c.screen_width  = ($urandom_range(0, 3) == 0) ? SCR_W'($urandom_range(1, 2047))
                                                          : SCR_W'($urandom_range(1, 400));
            c.screen_height = ($urandom_range(0, 3) == 0) ? SCR_W'($urandom_range(1, 2047))
                                                          : SCR_W'($urandom_range(1, 400));
            c.landscape     = 1'($urandom_range(0, 1));
            c.right_half    = 1'($urandom_range(0, 1));
            span = 32'(c.img_width);
            if (c.landscape)
                span = c.right_half ? 32'(c.img_width - (c.img_width >> 1))
                                    : 32'(c.img_width >> 1);
            if (span == 0)
                span = 1;
            c.scale_x = SCALE_W'((32'(c.screen_width) << FRAC_W) / span);
            c.scale_y = SCALE_W'((32'(c.screen_height) << FRAC_W) / 32'(c.img_height));
            if ($urandom_range(0, 9) == 0)
                c.scale_x = SCALE_W'($urandom_range(0, SCALE_TOP));
            if ($urandom_range(0, 9) == 0)
                c.scale_y = SCALE_W'($urandom_range(0, SCALE_TOP));
            apply_config(c);
            tx_steady = (f % 3 == 1);
            rx_steady = (f % 4 == 2);
            send_random_pixels(per_frame);
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial
    begin
        int held;
        forever
        begin
            if (hold_request > 0)
            begin
                held = hold_request;
                hold_request = 0;
                m_tready <= 1'b0;
                repeat (held) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            held = pick_gap(rx_steady);
            if (held > 0)
            begin
                m_tready <= 1'b0;
                repeat (held) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        dot_t got;
        dot_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.dest_x = m_tdata[SCR_W-1:0];
            got.dest_y = m_tdata[2*SCR_W-1:SCR_W];
            got.ink    = m_tdata[2*SCR_W];
            dots_checked++;
            if (expected_dots.size() == 0)
            begin
                if (error_count < 10)
                    $display("%0t: unexpected dot x=%0d y=%0d ink=%0b",
                             $realtime, got.dest_x, got.dest_y, got.ink);
                error_count++;
            end
            else
            begin
                want = expected_dots.pop_front();
                if (got.dest_x !== want.dest_x || got.dest_y !== want.dest_y ||
                    got.ink !== want.ink)
                begin
                    if (error_count < 10)
                        $display("%0t: dot expected x=%0d y=%0d ink=%0b, got x=%0d y=%0d ink=%0b",
                                 $realtime, want.dest_x, want.dest_y, want.ink,
                                 got.dest_x, got.dest_y, got.ink);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_empty_image();
        test_portrait_bounds();
        test_landscape_halves();
        test_scale_extremes();
        test_backpressure();
        test_random_frames(8, 69);
        drain_results(SETTLE_CYCLES);
        $display("Sent %0d pixels under %0d register settings and checked %0d dots,",
                 pixels_sent, configs_applied, dots_checked);
        $display("with random stalls on both sides and a %0d-cycle output hold-off.",
                 STALL_CYCLES);
        if (error_count == 0 && expected_dots.size() == 0)
            $display("scaled_gray_bayer_dither: match");
        else
            $display("scaled_gray_bayer_dither: mismatch");
        $finish;
    end

endmodule
